// ----- hdl/mfpl_pkg.sv -----
// shared constants and types for the majority filtered press latch
package mfpl_pkg;

    // default window length and its legal range
    localparam int WINDOW_DEFAULT = 8;
    localparam int WINDOW_MIN     = 1;
    localparam int WINDOW_MAX     = 64;

    // field widths
    localparam int MS_W   = 16;
    localparam int HOLD_W = 17;

    // hold limit after reset, and the saturation point of the hold timer
    localparam logic [MS_W-1:0]   HOLD_LIMIT_RESET = 16'd1000;
    localparam logic [HOLD_W-1:0] HOLD_MAX         = 17'h1FFFF;

    // per-request control handed from the filter to the hold timer
    typedef struct packed {
        logic            fire;
        logic            level_next;
        logic [MS_W-1:0] elapsed_ms;
    } step_t;

endpackage

// ----- hdl/mfpl_if.sv -----
// request channels: raw sample input and latch result output
interface mfpl_sample_if;
    logic                        valid;
    logic                        ready;
    logic                        sample_bit;
    logic [mfpl_pkg::MS_W-1:0]   elapsed_ms;

    modport source (output valid, output sample_bit, output elapsed_ms, input ready);
    modport sink   (input valid, input sample_bit, input elapsed_ms, output ready);
endinterface

interface mfpl_result_if;
    logic valid;
    logic ready;
    logic pressed;
    logic filtered_level;

    modport source (output valid, output pressed, output filtered_level, input ready);
    modport sink   (input valid, input pressed, input filtered_level, output ready);
endinterface

// ----- hdl/mfpl_cell.sv -----
// one window cell: holds a sample bit and passes it on at every accepted request
module mfpl_cell (
    input  logic clk,
    input  logic rst_n,
    input  logic shift,
    input  logic d,
    output logic q
);

    logic bit_reg;
    logic bit_next;

    // take the neighbor's bit on a shift
    always_comb
    begin
        bit_next = shift ? d : bit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 1'b0;
        end
        else
        begin
            bit_reg <= bit_next;
        end
    end

    assign q = bit_reg;

endmodule

// ----- hdl/mfpl_hold_timer.sv -----
// press latch with release hold timer
module mfpl_hold_timer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mfpl_pkg::step_t               step,
    input  logic [mfpl_pkg::MS_W-1:0]     hold_limit_ms,
    output logic                          pressed_next
);

    logic                          pressed_reg;
    logic                          running_reg;
    logic [mfpl_pkg::HOLD_W-1:0]   elapsed_reg;
    logic                          pressed_nx;
    logic                          running_next;
    logic [mfpl_pkg::HOLD_W-1:0]   elapsed_next;
    logic [mfpl_pkg::HOLD_W:0]     sum;

    assign sum = {1'b0, elapsed_reg} + (mfpl_pkg::HOLD_W + 1)'(step.elapsed_ms);

    // advance timer, release check, then press logic on the new level
    always_comb
    begin
        pressed_nx   = pressed_reg;
        running_next = running_reg;
        elapsed_next = elapsed_reg;
        if (running_reg)
        begin
            elapsed_next = sum[mfpl_pkg::HOLD_W] ? mfpl_pkg::HOLD_MAX
                                                 : sum[mfpl_pkg::HOLD_W-1:0];
        end
        if (elapsed_next > (mfpl_pkg::HOLD_W)'(hold_limit_ms))
        begin
            elapsed_next = '0;
            running_next = 1'b0;
            pressed_nx   = 1'b0;
        end
        if (step.level_next && !pressed_nx)
        begin
            pressed_nx   = 1'b1;
            running_next = 1'b0;
            elapsed_next = '0;
        end
        if (!step.level_next && pressed_nx)
        begin
            running_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg <= 1'b0;
            running_reg <= 1'b0;
            elapsed_reg <= '0;
        end
        else if (step.fire)
        begin
            pressed_reg <= pressed_nx;
            running_reg <= running_next;
            elapsed_reg <= elapsed_next;
        end
    end

    assign pressed_next = pressed_nx;

    // an idle timer holds no time
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> elapsed_reg == '0)
        else $error("hold timer idle with time accumulated");

    // the timer only runs while the latch is pressed
    a_run_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> pressed_reg)
        else $error("hold timer running while not pressed");

endmodule

// ----- hdl/majority_filtered_press_latch.sv -----
// top level: window cell chain, majority decision, hold timer and result register
//
//  channel   | dir | handshake          | payload
//  samples   | in  | valid/ready        | sample_bit, elapsed_ms
//  results   | out | valid/ready        | pressed, filtered_level
//  cfg       | in  | cfg_we (no ready)  | cfg_wdata -> hold_limit_ms
//
// one request per cycle when not stalled; its result is registered in the cycle after
// the cell chain shifts and the ones counter and hold timer update in the accept cycle
// reset clears the window, level, latch and timer, and loads a hold limit of 1000 ms
// a held result stalls input only when it is not taken in the same cycle
module majority_filtered_press_latch #(
    parameter int WINDOW = mfpl_pkg::WINDOW_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    mfpl_sample_if.sink                 samples,
    mfpl_result_if.source               results,
    input  logic                        cfg_we,
    input  logic [mfpl_pkg::MS_W-1:0]   cfg_wdata
);

    localparam int CW = $clog2(WINDOW + 1);
    localparam logic [CW:0] WIN_C = (CW + 1)'(WINDOW);

    logic                        fire;
    logic [WINDOW-1:0]           window_bits;
    logic                        oldest;
    logic [CW-1:0]               ones_reg;
    logic [CW-1:0]               ones_next;
    logic                        level_reg;
    logic                        level_next;
    logic [CW:0]                 same;
    logic [mfpl_pkg::MS_W-1:0]   hold_limit_reg;
    logic                        pressed_next;
    mfpl_pkg::step_t             step;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        out_pressed_reg;
    logic                        out_level_reg;

    assign samples.ready = !out_valid_reg || results.ready;
    assign fire          = samples.valid && samples.ready;

    // hold limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_limit_reg <= mfpl_pkg::HOLD_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            hold_limit_reg <= cfg_wdata;
        end
    end

    // sample window as a chain of cells, newest at cell zero
    genvar i;
    generate
        for (i = 0; i < WINDOW; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                mfpl_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (fire),
                    .d     (samples.sample_bit),
                    .q     (window_bits[0])
                );
            end
            else
            begin : g_body
                mfpl_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (fire),
                    .d     (window_bits[i-1]),
                    .q     (window_bits[i])
                );
            end
        end
    endgenerate

    assign oldest = window_bits[WINDOW-1];

    // running count of ones after the new sample replaces the oldest
    assign ones_next = ones_reg + CW'(samples.sample_bit) - CW'(oldest);

    // majority decision, ties go to the new sample
    always_comb
    begin
        same       = samples.sample_bit ? {1'b0, ones_next} : WIN_C - {1'b0, ones_next};
        level_next = level_reg;
        if (samples.sample_bit != level_reg)
        begin
            if ({same[CW-1:0], 1'b0} >= WIN_C)
            begin
                level_next = samples.sample_bit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ones_reg  <= '0;
            level_reg <= 1'b0;
        end
        else if (fire)
        begin
            ones_reg  <= ones_next;
            level_reg <= level_next;
        end
    end

    // hold timer and press latch
    assign step.fire       = fire;
    assign step.level_next = level_next;
    assign step.elapsed_ms = samples.elapsed_ms;

    mfpl_hold_timer u_timer (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .hold_limit_ms (hold_limit_reg),
        .pressed_next  (pressed_next)
    );

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_pressed_reg <= pressed_next;
            out_level_reg   <= level_next;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.pressed        = out_pressed_reg;
    assign results.filtered_level = out_level_reg;

    // the ones counter tracks the cell contents
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        ones_reg == CW'($countones(window_bits)))
        else $error("ones count out of step with window cells");

    // a high filtered level always leaves the latch pressed
    a_level_press: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.filtered_level |-> results.pressed)
        else $error("high level reported without press");

    // a result that is not taken blocks the next request
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.ready |-> !samples.ready)
        else $error("request accepted over a waiting result");

    // a request always leaves a result behind it
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> results.valid)
        else $error("accepted request produced no result");

endmodule

// ----- sim/majority_filtered_press_latch_tb.sv -----
// self-checking testbench for the majority filtered press latch
module majority_filtered_press_latch_tb;

    localparam int WIN         = mfpl_pkg::WINDOW_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_PAD   = 4;
    localparam int RAND_PHASES = 10;
    localparam int RAND_ITEMS  = 130;

    // receiver stall patterns
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_COMB} rx_mode_t;

    typedef struct {
        logic                      sample_bit;
        logic [mfpl_pkg::MS_W-1:0] elapsed_ms;
    } sample_req_t;

    typedef struct {
        logic pressed;
        logic filtered_level;
    } latch_out_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [mfpl_pkg::MS_W-1:0] cfg_wdata;

    mfpl_sample_if samp_ch();
    mfpl_result_if res_ch();

    majority_filtered_press_latch #(.WINDOW(WIN)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samp_ch),
        .results   (res_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // request queues and expected latch outputs
    sample_req_t pending_q[$];
    latch_out_t  latch_expect_q[$];

    // predictor state
    logic [WIN-1:0]              win_bits;
    int                          wr_pos;
    int                          ones_cnt;
    logic                        lvl;
    logic                        latched;
    logic                        hold_on;
    logic [mfpl_pkg::HOLD_W-1:0] hold_ms;
    logic [mfpl_pkg::MS_W-1:0]   hold_limit;

    // driver, receiver and run bookkeeping
    sample_req_t cur_req;
    bit          offering;
    int          gap_left;
    int          burst_left;
    rx_mode_t    rx_mode;
    int          mode_left;
    int          long_left;
    bit          long_done;
    logic        rdy_next;
    latch_out_t  exp_out;
    int          mismatches;
    int          results_seen;
    int          accepted;
    int          presses;
    int          releases;
    int          limits_used;
    int          cycles;

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // one step of the filter and hold latch, expectation queued
    function automatic void predict_press_step(input logic smp,
                                               input logic [mfpl_pkg::MS_W-1:0] dt);
        logic [mfpl_pkg::HOLD_W:0] sum;
        int same;
        if (hold_on)
        begin
            sum = hold_ms + dt;
            hold_ms = (sum > mfpl_pkg::HOLD_MAX) ? mfpl_pkg::HOLD_MAX
                                                 : sum[mfpl_pkg::HOLD_W-1:0];
        end
        if (hold_ms > hold_limit)
        begin
            if (latched)
                releases++;
            hold_ms = '0;
            hold_on = 1'b0;
            latched = 1'b0;
        end
        // circular window and running ones count
        if (win_bits[wr_pos])
            ones_cnt--;
        win_bits[wr_pos] = smp;
        if (smp)
            ones_cnt++;
        wr_pos = (wr_pos == WIN - 1) ? 0 : wr_pos + 1;
        // ties go to the new sample
        if (smp != lvl)
        begin
            same = smp ? ones_cnt : WIN - ones_cnt;
            if (same >= WIN - same)
                lvl = smp;
        end
        // press logic on the new level
        if (lvl && !latched)
        begin
            latched = 1'b1;
            hold_on = 1'b0;
            hold_ms = '0;
            presses++;
        end
        if (!lvl && latched)
            hold_on = 1'b1;
        latch_expect_q.push_back('{pressed: latched, filtered_level: lvl});
    endfunction

    // sender: bursts of random length with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            samp_ch.valid      <= 1'b0;
            samp_ch.sample_bit <= 1'b0;
            samp_ch.elapsed_ms <= '0;
            offering   = 1'b0;
            gap_left   = 0;
            burst_left = 0;
        end
        else
        begin
            if (samp_ch.valid && samp_ch.ready)
            begin
                predict_press_step(samp_ch.sample_bit, samp_ch.elapsed_ms);
                accepted++;
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_q.size() > 0)
                begin
                    cur_req  = pending_q.pop_front();
                    offering = 1'b1;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 40);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
            samp_ch.valid      <= offering;
            samp_ch.sample_bit <= cur_req.sample_bit;
            samp_ch.elapsed_ms <= cur_req.elapsed_ms;
        end
    end

    // receiver: stall modes that change at random intervals, one long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (!long_done && results_seen >= 200)
            begin
                long_left = 300;
                long_done = 1'b1;
            end
            if (long_left > 0)
            begin
                long_left--;
                rdy_next = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN:   rdy_next = 1'b1;
                    RX_COIN:   rdy_next = 1'($urandom_range(0, 1));
                    RX_SPARSE: rdy_next = ($urandom_range(0, 3) == 0);
                    default:   rdy_next = mode_left[1];
                endcase
            end
            res_ch.ready <= rdy_next;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            if (latch_expect_q.size() == 0)
            begin
                $error("unexpected result: pressed=%0b filtered_level=%0b",
                       res_ch.pressed, res_ch.filtered_level);
                mismatches++;
            end
            else
            begin
                exp_out = latch_expect_q.pop_front();
                if (res_ch.pressed !== exp_out.pressed)
                begin
                    $error("pressed: expected %0b, got %0b", exp_out.pressed, res_ch.pressed);
                    mismatches++;
                end
                if (res_ch.filtered_level !== exp_out.filtered_level)
                begin
                    $error("filtered_level: expected %0b, got %0b",
                           exp_out.filtered_level, res_ch.filtered_level);
                    mismatches++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, latch_expect_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic queue_sample(input logic smp, input logic [mfpl_pkg::MS_W-1:0] dt);
        pending_q.push_back('{sample_bit: smp, elapsed_ms: dt});
    endtask

    // mostly short times, with extremes and full-range values mixed in
    function automatic logic [mfpl_pkg::MS_W-1:0] pick_elapsed();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return (mfpl_pkg::MS_W)'($urandom_range(0, 65535));
            default: return (mfpl_pkg::MS_W)'($urandom_range(0, 400));
        endcase
    endfunction

    function automatic logic [mfpl_pkg::MS_W-1:0] pick_hold_limit();
        case ($urandom_range(0, 3))
            0:       return (mfpl_pkg::MS_W)'($urandom_range(0, 100));
            1:       return (mfpl_pkg::MS_W)'($urandom_range(100, 2000));
            2:       return (mfpl_pkg::MS_W)'($urandom_range(0, 65535));
            default: return mfpl_pkg::HOLD_LIMIT_RESET;
        endcase
    endfunction

    // runs of one level with occasional flips, and bursts of raw noise
    task automatic queue_random(input int n);
        int   left;
        int   len;
        logic run_bit;
        bit   noisy;
        left = n;
        while (left > 0)
        begin
            noisy   = ($urandom_range(0, 3) == 0);
            run_bit = 1'($urandom_range(0, 1));
            len     = noisy ? $urandom_range(1, 6) : $urandom_range(1, 12);
            for (int i = 0; i < len && left > 0; i++)
            begin
                if (noisy)
                    queue_sample(1'($urandom_range(0, 1)), pick_elapsed());
                else
                    queue_sample(run_bit ^ ($urandom_range(0, 7) == 0), pick_elapsed());
                left--;
            end
        end
    endtask

    // wait until every queued request is sent and every expected result is back
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_q.size() != 0 || offering || latch_expect_q.size() != 0);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic write_hold_limit(input logic [mfpl_pkg::MS_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        hold_limit = val;
        limits_used++;
    endtask

    // stimulus and phases
    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        samp_ch.valid      = 1'b0;
        samp_ch.sample_bit = 1'b0;
        samp_ch.elapsed_ms = '0;
        res_ch.ready       = 1'b0;
        win_bits     = '0;
        wr_pos       = 0;
        ones_cnt     = 0;
        lvl          = 1'b0;
        latched      = 1'b0;
        hold_on      = 1'b0;
        hold_ms      = '0;
        hold_limit   = mfpl_pkg::HOLD_LIMIT_RESET;
        rx_mode      = RX_OPEN;
        mode_left    = 0;
        long_left    = 0;
        long_done    = 1'b0;
        mismatches   = 0;
        results_seen = 0;
        accepted     = 0;
        presses      = 0;
        releases     = 0;
        limits_used  = 1;
        cycles       = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset limit: level equal to sample, tie press, hold up to and past the limit
        queue_sample(1'b0, 16'd0);
        queue_sample(1'b0, 16'hFFFF);
        queue_sample(1'b1, 16'd0);
        queue_sample(1'b1, 16'd10);
        queue_sample(1'b1, 16'd10);
        queue_sample(1'b1, 16'd0);
        queue_sample(1'b0, 16'd0);
        queue_sample(1'b0, 16'd600);
        queue_sample(1'b0, 16'd400);
        queue_sample(1'b0, 16'd1);
        queue_sample(1'b0, 16'd300);
        wait_drained();

        // zero limit: zero time holds, any nonzero time releases
        write_hold_limit(16'd0);
        repeat (5) queue_sample(1'b1, 16'd0);
        repeat (5) queue_sample(1'b0, 16'd0);
        queue_sample(1'b0, 16'd1);
        wait_drained();

        // largest limit with largest steps
        write_hold_limit(16'hFFFF);
        repeat (4) queue_sample(1'b1, 16'd0);
        repeat (4) queue_sample(1'b0, 16'hFFFF);
        wait_drained();

        // random phases, each under a fresh hold limit
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            write_hold_limit(pick_hold_limit());
            queue_random(RAND_ITEMS);
            wait_drained();
        end

        repeat (10) @(posedge clk);
        $display("%0d samples in, %0d results checked, %0d hold limits",
                 accepted, results_seen, limits_used);
        $display("%0d presses and %0d releases predicted", presses, releases);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/mfpl_pkg.sv
hdl/mfpl_if.sv
hdl/mfpl_cell.sv
hdl/mfpl_hold_timer.sv
hdl/majority_filtered_press_latch.sv
sim/majority_filtered_press_latch_tb.sv
